// ----- hw/rtl/tcd_pkg.sv -----
`default_nettype none
package tcd_pkg;

    localparam logic [7:0] IAC  = 8'd255;
    localparam logic [7:0] DONT = 8'd254;
    localparam logic [7:0] WILL = 8'd251;
    localparam logic [7:0] SB   = 8'd250;
    localparam logic [7:0] SE   = 8'd240;

    // Result queue depth; a word can push up to two events.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        MODE_DATA    = 3'd0,
        MODE_IAC     = 3'd1,
        MODE_NEG_OPT = 3'd2,
        MODE_SB_OPT  = 3'd3,
        MODE_SB_DATA = 3'd4,
        MODE_SB_IAC  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_NEG     = 3'd1,
        EV_CMD     = 3'd2,
        EV_SBSTART = 3'd3,
        EV_SBDATA  = 3'd4,
        EV_SBEND   = 3'd5,
        EV_INCOMP  = 3'd6
    } event_kind_t;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  command_code;
        logic [7:0]  option_code;
        logic [7:0]  value_byte;
        logic        run_last;
    } event_t;

    // Push request from the parser into the result queue.
    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
    } push_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tcd_parser.sv -----
`default_nettype none
module tcd_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           fire,
    input  wire logic [7:0]     rx_byte,
    input  wire logic           buffer_end,
    output tcd_pkg::push_t      push
);

    tcd_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     held_reg, held_next;
    logic [7:0]     subopt_reg, subopt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= tcd_pkg::MODE_DATA;
            held_reg   <= '0;
            subopt_reg <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            subopt_reg <= subopt_next;
        end
    end

    always_comb begin
        tcd_pkg::event_t ev0;
        tcd_pkg::event_t ev1;
        tcd_pkg::event_t inc;
        logic [1:0]      n;
        logic            cut_tail;

        ev0         = '0;
        ev1         = '0;
        inc         = '0;
        inc.kind    = tcd_pkg::EV_INCOMP;
        n           = 2'd0;
        cut_tail    = 1'b0;
        mode_next   = mode_reg;
        held_next   = held_reg;
        subopt_next = subopt_reg;

        unique case (mode_reg)
            tcd_pkg::MODE_IAC: begin
                if (rx_byte == tcd_pkg::IAC) begin
                    ev0.kind       = tcd_pkg::EV_DATA;
                    ev0.value_byte = tcd_pkg::IAC;
                    n              = 2'd1;
                    mode_next      = tcd_pkg::MODE_DATA;
                end else if (rx_byte >= tcd_pkg::WILL && rx_byte <= tcd_pkg::DONT) begin
                    held_next = rx_byte;
                    mode_next = tcd_pkg::MODE_NEG_OPT;
                end else if (rx_byte == tcd_pkg::SB) begin
                    mode_next = tcd_pkg::MODE_SB_OPT;
                end else begin
                    ev0.kind         = tcd_pkg::EV_CMD;
                    ev0.command_code = rx_byte;
                    n                = 2'd1;
                    mode_next        = tcd_pkg::MODE_DATA;
                end
            end
            tcd_pkg::MODE_NEG_OPT: begin
                ev0.kind         = tcd_pkg::EV_NEG;
                ev0.command_code = held_reg;
                ev0.option_code  = rx_byte;
                n                = 2'd1;
                mode_next        = tcd_pkg::MODE_DATA;
            end
            tcd_pkg::MODE_SB_OPT: begin
                subopt_next     = rx_byte;
                ev0.kind        = tcd_pkg::EV_SBSTART;
                ev0.option_code = rx_byte;
                n               = 2'd1;
                mode_next       = tcd_pkg::MODE_SB_DATA;
            end
            tcd_pkg::MODE_SB_DATA: begin
                if (rx_byte == tcd_pkg::IAC) begin
                    mode_next = tcd_pkg::MODE_SB_IAC;
                end else begin
                    ev0.kind        = tcd_pkg::EV_SBDATA;
                    ev0.option_code = subopt_reg;
                    ev0.value_byte  = rx_byte;
                    n               = 2'd1;
                end
            end
            tcd_pkg::MODE_SB_IAC: begin
                ev0.option_code = subopt_reg;
                n               = 2'd1;
                if (rx_byte == tcd_pkg::SE) begin
                    ev0.kind  = tcd_pkg::EV_SBEND;
                    mode_next = tcd_pkg::MODE_DATA;
                end else begin
                    ev0.kind       = tcd_pkg::EV_SBDATA;
                    ev0.value_byte = tcd_pkg::IAC;
                    mode_next      = tcd_pkg::MODE_SB_DATA;
                    // stray IAC in SB: emit 255 then the byte itself, unless the buffer ends on that byte
                    if (rx_byte != tcd_pkg::IAC) begin
                        if (buffer_end) begin
                            cut_tail = 1'b1;
                        end else begin
                            ev1.kind        = tcd_pkg::EV_SBDATA;
                            ev1.option_code = subopt_reg;
                            ev1.value_byte  = rx_byte;
                            n               = 2'd2;
                        end
                    end
                end
            end
            default: begin
                if (rx_byte == tcd_pkg::IAC) begin
                    mode_next = tcd_pkg::MODE_IAC;
                end else begin
                    ev0.kind       = tcd_pkg::EV_DATA;
                    ev0.value_byte = rx_byte;
                    n              = 2'd1;
                end
            end
        endcase

        // buffer cut mid-command; at most one event precedes it here
        if (buffer_end && (mode_next != tcd_pkg::MODE_DATA || cut_tail)) begin
            if (n == 2'd0) begin
                ev0 = inc;
            end else begin
                ev1 = inc;
            end
            n         = n + 2'd1;
            mode_next = tcd_pkg::MODE_DATA;
        end

        if (n == 2'd1) begin
            ev0.run_last = 1'b1;
        end
        if (n == 2'd2) begin
            ev1.run_last = 1'b1;
        end

        push.count = n;
        push.ev0   = ev0;
        push.ev1   = ev1;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tcd_event_queue.sv -----
`default_nettype none
module tcd_event_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tcd_pkg::push_t  push,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tcd_pkg::event_t      out_event
);

    tcd_pkg::event_t entry_reg [tcd_pkg::QDEPTH];
    logic [tcd_pkg::QAW-1:0] wp_reg, wp_next;
    logic [tcd_pkg::QAW-1:0] rp_reg, rp_next;
    logic [tcd_pkg::QAW:0]   cnt_reg, cnt_next;
    logic                    pop;

    assign out_valid = (cnt_reg != '0);
    assign out_event = entry_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    // two free slots guarantee space for the largest push
    assign room      = (cnt_reg <= (tcd_pkg::QAW+1)'(tcd_pkg::QDEPTH - 2));

    always_comb begin
        wp_next  = wp_reg + tcd_pkg::QAW'(push.count);
        rp_next  = rp_reg + tcd_pkg::QAW'(pop);
        cnt_next = cnt_reg + (tcd_pkg::QAW+1)'(push.count) - (tcd_pkg::QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wp_reg] <= push.ev0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wp_reg + tcd_pkg::QAW'(1)] <= push.ev1;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/telnet_command_deframer.sv -----
`default_nettype none
// Channel  Direction  Ports
// s_       in         s_valid, s_ready, s_rx_byte[7:0], s_buffer_end
// m_       out        m_valid, m_ready, m_event_kind[2:0], m_command_code[7:0],
//                     m_option_code[7:0], m_value_byte[7:0], m_run_last
//
// One input word per cycle while the queue has room; each word yields zero to two events.
// One event leaves per cycle with m_ready high; input register feeds a 4-entry event queue.
// Input register drains into the parser only while the queue has at least two free slots.
// aresetn (synchronous) returns the parser to data mode and empties the queue.
module telnet_command_deframer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       s_buffer_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_event_kind,
    output logic [7:0]      m_command_code,
    output logic [7:0]      m_option_code,
    output logic [7:0]      m_value_byte,
    output logic            m_run_last
);

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic            room;
    logic            fire;
    tcd_pkg::push_t  push;
    tcd_pkg::event_t head;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
            in_last_reg <= s_buffer_end;
        end
    end

    tcd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .rx_byte    (in_byte_reg),
        .buffer_end (in_last_reg),
        .push       (push)
    );

    tcd_event_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire ? push : '0),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_event (head)
    );

    assign m_event_kind   = head.kind;
    assign m_command_code = head.command_code;
    assign m_option_code  = head.option_code;
    assign m_value_byte   = head.value_byte;
    assign m_run_last     = head.run_last;

endmodule
`default_nettype wire

// ----- tb/telnet_command_deframer_checker.sv -----
`default_nettype none
module telnet_command_deframer_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       s_buffer_end,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [2:0] m_event_kind,
    input  wire logic [7:0] m_command_code,
    input  wire logic [7:0] m_option_code,
    input  wire logic [7:0] m_value_byte,
    input  wire logic       m_run_last,
    input  wire logic       end_of_test,
    output int              error_count,
    output int              events_pending
);
    import tcd_pkg::*;

    event_t     expected_events[$];
    mode_t      parse_mode;
    logic [7:0] verb_seen;
    logic [7:0] sub_opt;
    bit         leftover_checked;

    function automatic event_t make_event(event_kind_t kind, logic [7:0] cmd,
                                          logic [7:0] opt, logic [7:0] val);
        event_t ev;
        ev.kind         = kind;
        ev.command_code = cmd;
        ev.option_code  = opt;
        ev.value_byte   = val;
        ev.run_last     = 1'b0;
        return ev;
    endfunction

    function automatic int field_diff(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Advance the parser by one word and queue the events it yields.
    task automatic parse_word(input logic [7:0] b, input logic last);
        event_t evs[$];
        bit     cut_tail;
        cut_tail = 1'b0;
        case (parse_mode)
            MODE_IAC: begin
                if (b == IAC) begin
                    evs.push_back(make_event(EV_DATA, 8'd0, 8'd0, IAC));
                    parse_mode = MODE_DATA;
                end else if (b >= WILL && b <= DONT) begin
                    verb_seen  = b;
                    parse_mode = MODE_NEG_OPT;
                end else if (b == SB) begin
                    parse_mode = MODE_SB_OPT;
                end else begin
                    evs.push_back(make_event(EV_CMD, b, 8'd0, 8'd0));
                    parse_mode = MODE_DATA;
                end
            end
            MODE_NEG_OPT: begin
                evs.push_back(make_event(EV_NEG, verb_seen, b, 8'd0));
                parse_mode = MODE_DATA;
            end
            MODE_SB_OPT: begin
                sub_opt = b;
                evs.push_back(make_event(EV_SBSTART, 8'd0, b, 8'd0));
                parse_mode = MODE_SB_DATA;
            end
            MODE_SB_DATA: begin
                if (b == IAC)
                    parse_mode = MODE_SB_IAC;
                else
                    evs.push_back(make_event(EV_SBDATA, 8'd0, sub_opt, b));
            end
            MODE_SB_IAC: begin
                if (b == SE) begin
                    evs.push_back(make_event(EV_SBEND, 8'd0, sub_opt, 8'd0));
                    parse_mode = MODE_DATA;
                end else begin
                    evs.push_back(make_event(EV_SBDATA, 8'd0, sub_opt, IAC));
                    parse_mode = MODE_SB_DATA;
                    // stray IAC X: X itself is dropped when the buffer ends on it
                    if (b != IAC) begin
                        if (last)
                            cut_tail = 1'b1;
                        else
                            evs.push_back(make_event(EV_SBDATA, 8'd0, sub_opt, b));
                    end
                end
            end
            default: begin
                if (b == IAC)
                    parse_mode = MODE_IAC;
                else
                    evs.push_back(make_event(EV_DATA, 8'd0, 8'd0, b));
            end
        endcase
        if (last && (parse_mode != MODE_DATA || cut_tail)) begin
            evs.push_back(make_event(EV_INCOMP, 8'd0, 8'd0, 8'd0));
            parse_mode = MODE_DATA;
        end
        if (evs.size() > 0)
            evs[evs.size() - 1].run_last = 1'b1;
        foreach (evs[i])
            expected_events.push_back(evs[i]);
    endtask

    task automatic check_event();
        event_t want;
        int     bad;
        if (expected_events.size() == 0) begin
            $display("%0t: event kind expected none actual %0d (value %0d)",
                     $time, m_event_kind, m_value_byte);
            error_count++;
        end else begin
            want = expected_events.pop_front();
            bad  = field_diff("event_kind", want.kind, m_event_kind)
                 + field_diff("command_code", want.command_code, m_command_code)
                 + field_diff("option_code", want.option_code, m_option_code)
                 + field_diff("value_byte", want.value_byte, m_value_byte)
                 + field_diff("run_last", want.run_last, m_run_last);
            if (bad != 0)
                error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_mode = MODE_DATA;
            verb_seen  = 8'd0;
            sub_opt    = 8'd0;
            expected_events.delete();
        end else begin
            if (m_valid && m_ready)
                check_event();
            if (s_valid && s_ready)
                parse_word(s_rx_byte, s_buffer_end);
            if (end_of_test && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (expected_events.size() != 0) begin
                    $display("%0t: events expected %0d actual 0 (never delivered)",
                             $time, expected_events.size());
                    error_count += expected_events.size();
                end
            end
        end
        events_pending = expected_events.size();
    end

endmodule
`default_nettype wire

// ----- tb/telnet_command_deframer_test.sv -----
`default_nettype none
module telnet_command_deframer_test;
    import tcd_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RAND_WORDS  = 900;
    localparam logic [7:0] WONT        = 8'd252;
    localparam logic [7:0] DO_CMD      = 8'd253;
    localparam logic [7:0] NOP         = 8'd241;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       s_buffer_end;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_event_kind;
    logic [7:0] m_command_code;
    logic [7:0] m_option_code;
    logic [7:0] m_value_byte;
    logic       m_run_last;
    logic       end_of_test;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int words_sent     = 0;
    int checker_errors;
    int events_open;

    telnet_command_deframer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_buffer_end   (s_buffer_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_command_code (m_command_code),
        .m_option_code  (m_option_code),
        .m_value_byte   (m_value_byte),
        .m_run_last     (m_run_last)
    );

    telnet_command_deframer_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_buffer_end   (s_buffer_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_command_code (m_command_code),
        .m_option_code  (m_option_code),
        .m_value_byte   (m_value_byte),
        .m_run_last     (m_run_last),
        .end_of_test    (end_of_test),
        .error_count    (checker_errors),
        .events_pending (events_open)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("telnet_command_deframer regression: fail");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Called right after the previous word was taken (or after reset).
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_rx_byte    <= b;
        s_buffer_end <= last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Mostly well-formed commands with random content; random buffer ends cut some.
    task automatic send_random_sequence();
        logic [7:0] seq[$];
        int         pick;
        int         n;
        logic       last;
        pick = $urandom_range(99);
        if (pick < 25) begin
            n = $urandom_range(1, 4);
            repeat (n) seq.push_back(8'($urandom_range(0, 254)));
        end else if (pick < 32) begin
            seq.push_back(IAC);
            seq.push_back(IAC);
        end else if (pick < 52) begin
            seq.push_back(IAC);
            seq.push_back(8'($urandom_range(WILL, DONT)));
            seq.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 62) begin
            seq.push_back(IAC);
            seq.push_back(8'($urandom_range(0, SB - 1)));
        end else if (pick < 92) begin
            seq.push_back(IAC);
            seq.push_back(SB);
            seq.push_back(8'($urandom_range(0, 255)));
            n = $urandom_range(0, 5);
            repeat (n) begin
                if ($urandom_range(4) == 0) begin
                    seq.push_back(IAC);
                    seq.push_back($urandom_range(1) ? IAC : 8'($urandom_range(0, 254)));
                end else begin
                    seq.push_back(8'($urandom_range(0, 254)));
                end
            end
            seq.push_back(IAC);
            seq.push_back(SE);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) seq.push_back(8'($urandom_range(0, 255)));
        end
        foreach (seq[i]) begin
            last = ($urandom_range(99) < 6)
                || (i == seq.size() - 1 && $urandom_range(99) < 10);
            send_word(seq[i], last);
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_byte    = 8'd0;
        s_buffer_end = 1'b0;
        end_of_test  = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // data extremes, literal 255 ending a buffer
        send_word(8'h00, 1'b0);
        send_word(IAC, 1'b0);
        send_word(IAC, 1'b1);
        // all four verbs, option extremes
        send_word(IAC, 1'b0);
        send_word(WILL, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(IAC, 1'b0);
        send_word(WONT, 1'b0);
        send_word(8'h7f, 1'b0);
        send_word(IAC, 1'b0);
        send_word(DO_CMD, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(IAC, 1'b0);
        send_word(DONT, 1'b0);
        send_word(8'hff, 1'b1);
        // subnegotiation with doubled IAC and a stray IAC X
        send_word(IAC, 1'b0);
        send_word(SB, 1'b0);
        send_word(8'h18, 1'b0);
        send_word(IAC, 1'b0);
        send_word(IAC, 1'b0);
        send_word(IAC, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(IAC, 1'b0);
        send_word(SE, 1'b0);
        // plain command, then buffer cut right after IAC
        send_word(IAC, 1'b0);
        send_word(NOP, 1'b0);
        send_word(IAC, 1'b1);
        // buffer ends on the X of a stray IAC X inside a subnegotiation
        send_word(IAC, 1'b0);
        send_word(SB, 1'b0);
        send_word(8'h05, 1'b0);
        send_word(IAC, 1'b0);
        send_word(8'h07, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            int target;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            target = words_sent + RAND_WORDS / 4;
            while (words_sent < target)
                send_random_sequence();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (events_open != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(negedge aclk);
        if (checker_errors == 0)
            $display("telnet_command_deframer regression: pass");
        else
            $display("telnet_command_deframer regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
